### sv/gnfs_pkg.sv
// Shared constants, register codes and divider transaction types for the
// grid nearest free site search unit. No dependencies.
package gnfs_pkg;

   localparam int MAX_ROWS_DEF  = 64;
   localparam int MAX_SITES_DEF = 64;

   localparam int CNT_W      = 11;
   localparam int COORD_W    = 24;
   localparam int PITCH_W    = 16;
   localparam int NUM_W      = 26;
   localparam int SIZE_W     = 7;
   localparam int IDX_W      = 6;
   localparam int KIND_W     = 2;
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 24;

   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MARK   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_SITES      = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_SITE_PITCH = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH  = 3'd5;

   typedef struct packed {
      logic               start;
      logic [NUM_W-1:0]   num;
      logic [PITCH_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
   } div_rsp_type;

endpackage

### sv/gnfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gnfs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/gnfs_div.sv
// Restoring divider, one quotient bit per cycle, shared by all index
// conversions. Depends on gnfs_pkg.
module gnfs_div (
   input  logic                 clock,
   input  logic                 reset,
   input  gnfs_pkg::div_req_type req,
   output gnfs_pkg::div_rsp_type rsp
);

   localparam int CW = $clog2(gnfs_pkg::NUM_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [gnfs_pkg::PITCH_W-1:0]  rem_ff, rem_in;
   logic [gnfs_pkg::NUM_W-1:0]    quo_ff, quo_in;
   logic [gnfs_pkg::PITCH_W-1:0]  den_ff, den_in;
   logic [gnfs_pkg::PITCH_W:0]    trial;
   logic [gnfs_pkg::PITCH_W:0]    diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[gnfs_pkg::NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.num;
         den_in  = req.den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[gnfs_pkg::PITCH_W-1:0];
            quo_in = {quo_ff[gnfs_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[gnfs_pkg::PITCH_W-1:0];
            quo_in = {quo_ff[gnfs_pkg::NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(gnfs_pkg::NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

### sv/grid_nearest_free_site_search_unit.sv
// Top level of the grid nearest free site search unit: sequencer, config
// registers and maps. Depends on gnfs_pkg, gnfs_ram and gnfs_div.
//
// One transaction at a time; req_stall is high while a transaction works.
// After reset a clearing pass over all 2**(row bits + site bits) cells (4096
// at the 64 by 64 default) empties the occupancy and seen maps before the
// first transaction is taken. A clear transaction sweeps the occupancy map
// only. A mark transaction runs four divisions on the shared divider, then
// writes each covered cell. A search visits cells in breadth-first order
// through the registered-read occupancy, seen and queue memories, then
// clears the seen map again for each queued cell. The search result sits
// in an output register, so a new transaction may start before it is
// taken.
module grid_nearest_free_site_search_unit #(
   parameter int MAX_ROWS  = gnfs_pkg::MAX_ROWS_DEF,
   parameter int MAX_SITES = gnfs_pkg::MAX_SITES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [gnfs_pkg::KIND_W-1:0]        req_kind,
   input  logic [gnfs_pkg::COORD_W-1:0]       req_block_x,
   input  logic [gnfs_pkg::COORD_W-1:0]       req_block_y,
   input  logic [gnfs_pkg::COORD_W-1:0]       req_block_width,
   input  logic [gnfs_pkg::COORD_W-1:0]       req_block_height,
   input  logic [gnfs_pkg::IDX_W-1:0]         req_start_row,
   input  logic [gnfs_pkg::IDX_W-1:0]         req_start_site,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic [gnfs_pkg::IDX_W-1:0]         rsp_free_row,
   output logic [gnfs_pkg::IDX_W-1:0]         rsp_free_site,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gnfs_pkg::CFG_IDX_W-1:0]     csr_index,
   input  logic [gnfs_pkg::CFG_DATA_W-1:0]    csr_data
);

   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int SW    = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
   localparam int CW    = RW + SW;
   localparam int DEPTH = 1 << CW;
   localparam int NW    = gnfs_pkg::NUM_W;
   localparam int KW    = gnfs_pkg::CNT_W;

   typedef enum logic [3:0] {
      ST_WIPE, ST_IDLE, ST_MDIV, ST_MWAIT, ST_MBOUND, ST_MFILL, ST_SSTART,
      ST_POP, ST_CELL, ST_OCC, ST_NB, ST_SEEN, ST_RESULT, ST_CLN
   } state_type;

   state_type state_ff, state_in;

   logic [gnfs_pkg::SIZE_W-1:0]  rows_ff, rows_in, sites_ff, sites_in;
   logic [gnfs_pkg::COORD_W-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [gnfs_pkg::PITCH_W-1:0] sp_ff, sp_in, rp_ff, rp_in;

   logic [gnfs_pkg::COORD_W-1:0] bx_ff, bx_in, by_ff, by_in, bw_ff, bw_in, bh_ff, bh_in;
   logic [gnfs_pkg::IDX_W-1:0]   sr_ff, sr_in, ss_ff, ss_in;

   logic [CW-1:0]  wcnt_ff, wcnt_in;
   logic           wseen_ff, wseen_in;
   logic [1:0]     sel_ff, sel_in;
   logic [NW-1:0]  q_ff [4];
   logic [NW-1:0]  q_in [4];
   logic [3:0]     n_ff, n_in;
   logic [RW-1:0]  rhi_ff, rhi_in, r_ff, r_in;
   logic [SW-1:0]  slo_ff, slo_in, shi_ff, shi_in, s_ff, s_in;

   logic [CW:0]    head_ff, head_in, tail_ff, tail_in, idx_ff, idx_in;
   logic [CW-1:0]  cell_ff, cell_in, nbc_ff, nbc_in;
   logic [1:0]     nb_ff, nb_in;
   logic           found_ff, found_in;
   logic           clv_ff, clv_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [gnfs_pkg::IDX_W-1:0]   rsp_row_ff, rsp_row_in, rsp_site_ff, rsp_site_in;

   gnfs_pkg::div_req_type div_req;
   gnfs_pkg::div_rsp_type div_rsp;

   logic          occ_we, occ_wd, occ_rd;
   logic [CW-1:0] occ_wa;
   logic          seen_we, seen_wd, seen_rd;
   logic [CW-1:0] seen_wa, seen_ra;
   logic          que_we;
   logic [CW-1:0] que_wa, que_wd, que_ra, que_rd;

   logic [KW-1:0] er, es;
   logic [NW-1:0] num [4];
   logic [NW-1:0] cur_num;
   logic [RW-1:0] cr;
   logic [SW-1:0] cs;
   logic [KW-1:0] cr_k, cs_k;
   logic [KW-1:0] sr_k, ss_k;
   logic          nb_ok;
   logic [CW-1:0] nb_cell;
   logic [NW-1:0] lo_r, hi_r, lim_r, hic_r, lo_s, hi_s, lim_s, hic_s;
   logic          empty;

   gnfs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   gnfs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_occ (
      .clock   (clock),
      .wr_en   (occ_we),
      .wr_addr (occ_wa),
      .wr_data (occ_wd),
      .rd_addr (que_rd),
      .rd_data (occ_rd)
   );

   gnfs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_seen (
      .clock   (clock),
      .wr_en   (seen_we),
      .wr_addr (seen_wa),
      .wr_data (seen_wd),
      .rd_addr (seen_ra),
      .rd_data (seen_rd)
   );

   gnfs_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_queue (
      .clock   (clock),
      .wr_en   (que_we),
      .wr_addr (que_wa),
      .wr_data (que_wd),
      .rd_addr (que_ra),
      .rd_data (que_rd)
   );

   always_comb begin
      er = (KW'(rows_ff) > KW'(MAX_ROWS)) ? KW'(MAX_ROWS) : KW'(rows_ff);
      es = (KW'(sites_ff) > KW'(MAX_SITES)) ? KW'(MAX_SITES) : KW'(sites_ff);

      num[0] = NW'(by_ff) - NW'(oy_ff);
      num[1] = NW'(by_ff) + NW'(bh_ff) - NW'(oy_ff);
      num[2] = NW'(bx_ff) - NW'(ox_ff);
      num[3] = NW'(bx_ff) + NW'(bw_ff) - NW'(ox_ff);
      cur_num = num[sel_ff];
      div_req.start = (state_ff == ST_MDIV);
      div_req.num   = cur_num[NW-1] ? (~cur_num + NW'(1)) : cur_num;
      if (sel_ff[1]) begin
         div_req.den = (sp_ff == '0) ? gnfs_pkg::PITCH_W'(1) : sp_ff;
      end else begin
         div_req.den = (rp_ff == '0) ? gnfs_pkg::PITCH_W'(1) : rp_ff;
      end

      lo_r  = n_ff[0] ? '0 : q_ff[0];
      hi_r  = n_ff[1] ? '0 : q_ff[1];
      lim_r = NW'(er) - NW'(1);
      hic_r = (hi_r > lim_r) ? lim_r : hi_r;
      lo_s  = n_ff[2] ? '0 : q_ff[2];
      hi_s  = n_ff[3] ? '0 : q_ff[3];
      lim_s = NW'(es) - NW'(1);
      hic_s = (hi_s > lim_s) ? lim_s : hi_s;
      empty = (er == '0) || (es == '0)
            || (n_ff[1] && q_ff[1] != '0) || (n_ff[3] && q_ff[3] != '0)
            || (lo_r > hic_r) || (lo_s > hic_s);

      cr   = cell_ff[CW-1:SW];
      cs   = cell_ff[SW-1:0];
      cr_k = KW'(cr);
      cs_k = KW'(cs);
      sr_k = KW'(sr_ff);
      ss_k = KW'(ss_ff);
      nb_ok   = 1'b0;
      nb_cell = cell_ff;
      case (nb_ff)
         2'd0: begin
            nb_ok   = (cr_k + KW'(1)) < er;
            nb_cell = {cr + RW'(1), cs};
         end
         2'd1: begin
            nb_ok   = (cr != '0);
            nb_cell = {cr - RW'(1), cs};
         end
         2'd2: begin
            nb_ok   = (cs_k + KW'(1)) < es;
            nb_cell = {cr, cs + SW'(1)};
         end
         default: begin
            nb_ok   = (cs != '0);
            nb_cell = {cr, cs - SW'(1)};
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      rows_in  = rows_ff;
      sites_in = sites_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      sp_in    = sp_ff;
      rp_in    = rp_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      bw_in    = bw_ff;
      bh_in    = bh_ff;
      sr_in    = sr_ff;
      ss_in    = ss_ff;
      wcnt_in  = wcnt_ff;
      wseen_in = wseen_ff;
      sel_in   = sel_ff;
      q_in     = q_ff;
      n_in     = n_ff;
      rhi_in   = rhi_ff;
      slo_in   = slo_ff;
      shi_in   = shi_ff;
      r_in     = r_ff;
      s_in     = s_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      idx_in   = idx_ff;
      cell_in  = cell_ff;
      nbc_in   = nbc_ff;
      nb_in    = nb_ff;
      found_in = found_ff;
      clv_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_site_in  = rsp_site_ff;

      occ_we  = 1'b0;
      occ_wa  = wcnt_ff;
      occ_wd  = 1'b0;
      seen_we = 1'b0;
      seen_wa = wcnt_ff;
      seen_wd = 1'b0;
      seen_ra = nb_cell;
      que_we  = 1'b0;
      que_wa  = tail_ff[CW-1:0];
      que_wd  = nbc_ff;
      que_ra  = head_ff[CW-1:0];

      if (csr_valid) begin
         unique case (csr_index)
            gnfs_pkg::REG_ROWS:       rows_in  = csr_data[gnfs_pkg::SIZE_W-1:0];
            gnfs_pkg::REG_SITES:      sites_in = csr_data[gnfs_pkg::SIZE_W-1:0];
            gnfs_pkg::REG_ORIGIN_X:   ox_in    = csr_data;
            gnfs_pkg::REG_ORIGIN_Y:   oy_in    = csr_data;
            gnfs_pkg::REG_SITE_PITCH: sp_in    = csr_data[gnfs_pkg::PITCH_W-1:0];
            gnfs_pkg::REG_ROW_PITCH:  rp_in    = csr_data[gnfs_pkg::PITCH_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_WIPE: begin
            occ_we  = 1'b1;
            seen_we = wseen_ff;
            wcnt_in = wcnt_ff + CW'(1);
            if (wcnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               bx_in   = req_block_x;
               by_in   = req_block_y;
               bw_in   = req_block_width;
               bh_in   = req_block_height;
               sr_in   = req_start_row;
               ss_in   = req_start_site;
               wcnt_in  = '0;
               wseen_in = 1'b0;
               sel_in   = '0;
               case (req_kind)
                  gnfs_pkg::KIND_CLEAR:  state_in = ST_WIPE;
                  gnfs_pkg::KIND_MARK:   state_in = ST_MDIV;
                  gnfs_pkg::KIND_SEARCH: state_in = ST_SSTART;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_MDIV: begin
            state_in = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (div_rsp.done) begin
               q_in[sel_ff] = div_rsp.quot;
               n_in[sel_ff] = cur_num[NW-1];
               sel_in       = sel_ff + 2'd1;
               state_in     = (sel_ff == 2'd3) ? ST_MBOUND : ST_MDIV;
            end
         end
         ST_MBOUND: begin
            rhi_in = hic_r[RW-1:0];
            slo_in = lo_s[SW-1:0];
            shi_in = hic_s[SW-1:0];
            r_in   = lo_r[RW-1:0];
            s_in   = lo_s[SW-1:0];
            state_in = empty ? ST_IDLE : ST_MFILL;
         end
         ST_MFILL: begin
            occ_we = 1'b1;
            occ_wa = {r_ff, s_ff};
            occ_wd = 1'b1;
            if (s_ff == shi_ff) begin
               s_in = slo_ff;
               r_in = r_ff + RW'(1);
               if (r_ff == rhi_ff) begin
                  state_in = ST_IDLE;
               end
            end else begin
               s_in = s_ff + SW'(1);
            end
         end
         ST_SSTART: begin
            head_in  = '0;
            found_in = 1'b0;
            cell_in  = '0;
            if (sr_k >= er || ss_k >= es) begin
               tail_in  = '0;
               state_in = ST_RESULT;
            end else begin
               seen_we  = 1'b1;
               seen_wa  = {sr_k[RW-1:0], ss_k[SW-1:0]};
               seen_wd  = 1'b1;
               que_we   = 1'b1;
               que_wa   = '0;
               que_wd   = {sr_k[RW-1:0], ss_k[SW-1:0]};
               tail_in  = (CW + 1)'(1);
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (head_ff == tail_ff) begin
               cell_in  = '0;
               state_in = ST_RESULT;
            end else begin
               head_in  = head_ff + (CW + 1)'(1);
               state_in = ST_CELL;
            end
         end
         ST_CELL: begin
            cell_in  = que_rd;
            state_in = ST_OCC;
         end
         ST_OCC: begin
            nb_in = '0;
            if (!occ_rd) begin
               found_in = 1'b1;
               state_in = ST_RESULT;
            end else begin
               state_in = ST_NB;
            end
         end
         ST_NB: begin
            nbc_in = nb_cell;
            if (nb_ok) begin
               state_in = ST_SEEN;
            end else begin
               nb_in    = nb_ff + 2'd1;
               state_in = (nb_ff == 2'd3) ? ST_POP : ST_NB;
            end
         end
         ST_SEEN: begin
            if (!seen_rd) begin
               seen_we = 1'b1;
               seen_wa = nbc_ff;
               seen_wd = 1'b1;
               que_we  = 1'b1;
               tail_in = tail_ff + (CW + 1)'(1);
            end
            nb_in    = nb_ff + 2'd1;
            state_in = (nb_ff == 2'd3) ? ST_POP : ST_NB;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_row_in   = found_ff ? gnfs_pkg::IDX_W'(cr) : '0;
               rsp_site_in  = found_ff ? gnfs_pkg::IDX_W'(cs) : '0;
               idx_in       = '0;
               state_in     = ST_CLN;
            end
         end
         ST_CLN: begin
            que_ra = idx_ff[CW-1:0];
            if (clv_ff) begin
               seen_we = 1'b1;
               seen_wa = que_rd;
               seen_wd = 1'b0;
            end
            if (idx_ff != tail_ff) begin
               clv_in = 1'b1;
               idx_in = idx_ff + (CW + 1)'(1);
            end else if (!clv_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         wcnt_ff      <= '0;
         wseen_ff     <= 1'b1;
         rows_ff      <= gnfs_pkg::SIZE_W'(64);
         sites_ff     <= gnfs_pkg::SIZE_W'(64);
         ox_ff        <= '0;
         oy_ff        <= '0;
         sp_ff        <= gnfs_pkg::PITCH_W'(1);
         rp_ff        <= gnfs_pkg::PITCH_W'(1);
         head_ff      <= '0;
         tail_ff      <= '0;
         clv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wcnt_ff      <= wcnt_in;
         wseen_ff     <= wseen_in;
         rows_ff      <= rows_in;
         sites_ff     <= sites_in;
         ox_ff        <= ox_in;
         oy_ff        <= oy_in;
         sp_ff        <= sp_in;
         rp_ff        <= rp_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         clv_ff       <= clv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      bw_ff       <= bw_in;
      bh_ff       <= bh_in;
      sr_ff       <= sr_in;
      ss_ff       <= ss_in;
      sel_ff      <= sel_in;
      q_ff        <= q_in;
      n_ff        <= n_in;
      rhi_ff      <= rhi_in;
      slo_ff      <= slo_in;
      shi_ff      <= shi_in;
      r_ff        <= r_in;
      s_ff        <= s_in;
      idx_ff      <= idx_in;
      cell_ff     <= cell_in;
      nbc_ff      <= nbc_in;
      nb_ff       <= nb_in;
      found_ff    <= found_in;
      rsp_found_ff <= rsp_found_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_site_ff <= rsp_site_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_free_row  = rsp_row_ff;
   assign rsp_free_site = rsp_site_ff;

endmodule
